// ----- hw/rtl/rbs_pkg.sv -----
// shared constants, types and codes for the ray-box slab intersection block
// no dependencies
`default_nettype none
package rbs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;
    localparam int QW        = CW + 1 + FRAC_BITS;
    localparam int LANE_LAT  = QW + 1;

    localparam logic signed [CW-1:0] T_LOW  = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] T_HIGH = {1'b0, {(CW-1){1'b1}}};

    typedef enum logic [2:0] {
        REG_MIN_X    = 3'd0,
        REG_MIN_Y    = 3'd1,
        REG_MIN_Z    = 3'd2,
        REG_MAX_X    = 3'd3,
        REG_MAX_Y    = 3'd4,
        REG_MAX_Z    = 3'd5,
        REG_HIT_TOL  = 3'd6,
        REG_FACE_TOL = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        FACE_NONE  = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_X = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Y = 3'd4,
        FACE_NEG_Z = 3'd5,
        FACE_POS_Z = 3'd6
    } t_face;

    typedef struct packed {
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi;
        logic                 miss;
    } t_lane_res;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] t;
        logic                 in_box;
    } t_merge_res;

    typedef struct packed {
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic signed [CW-1:0] oz;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] dz;
        logic [30:0]          closest;
    } t_ray;

endpackage
`default_nettype wire

// ----- hw/rtl/rbs_in_if.sv -----
// ray request channel: valid, ready and ray payload
// no dependencies
`default_nettype none
interface rbs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        closest_t;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    closest_t, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  closest_t, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/rbs_out_if.sv -----
// hit result channel: valid, ready and hit payload
// no dependencies
`default_nettype none
interface rbs_out_if;
    logic               valid;
    logic               ready;
    logic               hit_found;
    logic [30:0]        hit_t;
    logic signed [31:0] hit_pos_x;
    logic signed [31:0] hit_pos_y;
    logic signed [31:0] hit_pos_z;
    logic [2:0]         face_code;
    logic               from_inside;

    modport source (output valid, hit_found, hit_t, hit_pos_x, hit_pos_y, hit_pos_z,
                    face_code, from_inside, input ready);
    modport sink (input valid, hit_found, hit_t, hit_pos_x, hit_pos_y, hit_pos_z,
                  face_code, from_inside, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ray_box_slab_intersect.sv -----
// ray against axis-aligned box, slab method, Q16.16 fixed point
// depends on rbs_pkg, rbs_in_if, rbs_out_if, rbs_lane, rbs_merge
//
// One ray request is taken every clock cycle while the result side keeps up; the whole
// pipeline stalls together when a result waits. A request passes the bit-per-stage slab
// dividers in the three axis lanes, then the lane merge, the hit-point multiply, the
// saturating add and the face match with the output register. The user writes box
// registers through the plain write port only while no request is in flight; the block
// itself does not enforce it.
`default_nettype none
module ray_box_slab_intersect (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    rbs_in_if.sink           i_ray,
    rbs_out_if.source        o_hit
);
    import rbs_pkg::*;

    logic signed [31:0] r_bmin [0:2];
    logic signed [31:0] r_bmax [0:2];
    logic [15:0]        r_hit_tol, r_face_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_bmin[a] <= '0;
                r_bmax[a] <= 32'sd65536;
            end
            r_hit_tol  <= 16'd1;
            r_face_tol <= 16'd7;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_MIN_X:    r_bmin[0]  <= i_cfg_data;
                REG_MIN_Y:    r_bmin[1]  <= i_cfg_data;
                REG_MIN_Z:    r_bmin[2]  <= i_cfg_data;
                REG_MAX_X:    r_bmax[0]  <= i_cfg_data;
                REG_MAX_Y:    r_bmax[1]  <= i_cfg_data;
                REG_MAX_Z:    r_bmax[2]  <= i_cfg_data;
                REG_HIT_TOL:  r_hit_tol  <= i_cfg_data[15:0];
                REG_FACE_TOL: r_face_tol <= i_cfg_data[15:0];
            endcase
        end
    end

    logic en;
    logic r_out_valid;
    assign en          = !r_out_valid || o_hit.ready;
    assign i_ray.ready = en;

    t_ray ray_in;
    assign ray_in = '{ox: i_ray.origin_x, oy: i_ray.origin_y, oz: i_ray.origin_z,
                      dx: i_ray.dir_x, dy: i_ray.dir_y, dz: i_ray.dir_z,
                      closest: i_ray.closest_t};

    // ray payload and valid ride alongside the lanes
    t_ray r_dly   [0:LANE_LAT-1];
    logic r_dly_v [0:LANE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= ray_in;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANE_LAT; k++) begin
                r_dly_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_dly_v[0] <= i_ray.valid;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_dly_v[k] <= r_dly_v[k-1];
            end
        end
    end

    t_lane_res lx, ly, lz;

    rbs_lane u_lane_x (
        .i_clk (i_clk), .i_en (en), .i_bmin (r_bmin[0]), .i_bmax (r_bmax[0]),
        .i_org (i_ray.origin_x), .i_dir (i_ray.dir_x), .o_res (lx)
    );
    rbs_lane u_lane_y (
        .i_clk (i_clk), .i_en (en), .i_bmin (r_bmin[1]), .i_bmax (r_bmax[1]),
        .i_org (i_ray.origin_y), .i_dir (i_ray.dir_y), .o_res (ly)
    );
    rbs_lane u_lane_z (
        .i_clk (i_clk), .i_en (en), .i_bmin (r_bmin[2]), .i_bmax (r_bmax[2]),
        .i_org (i_ray.origin_z), .i_dir (i_ray.dir_z), .o_res (lz)
    );

    t_ray       dly_last;
    t_merge_res mres;
    assign dly_last = r_dly[LANE_LAT-1];

    rbs_merge u_merge (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_lx      (lx),
        .i_ly      (ly),
        .i_lz      (lz),
        .i_hit_tol (r_hit_tol),
        .i_closest (dly_last.closest),
        .o_res     (mres)
    );

    // ray stage beside the merge register, multiply stage, add stage
    t_ray               r_m_ray;
    logic               r_m_valid, r_p_valid, r_q_valid;
    t_merge_res         r_p_res, r_q_res;
    logic signed [31:0] r_p_org [0:2];
    logic [30:0]        r_p_clo, r_q_clo;
    logic signed [63:0] r_p_prod [0:2];
    logic signed [31:0] r_q_pos [0:2];

    logic signed [31:0] m_dir [0:2];
    logic signed [31:0] m_org [0:2];
    assign m_dir[0] = r_m_ray.dx;
    assign m_dir[1] = r_m_ray.dy;
    assign m_dir[2] = r_m_ray.dz;
    assign m_org[0] = r_m_ray.ox;
    assign m_org[1] = r_m_ray.oy;
    assign m_org[2] = r_m_ray.oz;

    logic signed [47:0] q_sum [0:2];
    logic signed [31:0] q_sat [0:2];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            q_sum[a] = 48'(r_p_org[a]) + 48'(r_p_prod[a] >>> FRAC_BITS);
            if (q_sum[a] < 48'(T_LOW)) begin
                q_sat[a] = T_LOW;
            end else if (q_sum[a] > 48'(T_HIGH)) begin
                q_sat[a] = T_HIGH;
            end else begin
                q_sat[a] = q_sum[a][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_ray <= dly_last;
            r_p_res <= mres;
            r_p_clo <= r_m_ray.closest;
            for (int a = 0; a < 3; a++) begin
                r_p_org[a]  <= m_org[a];
                r_p_prod[a] <= mres.t * m_dir[a];
                r_q_pos[a]  <= q_sat[a];
            end
            r_q_res <= r_p_res;
            r_q_clo <= r_p_clo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_q_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= r_dly_v[LANE_LAT-1];
            r_p_valid <= r_m_valid;
            r_q_valid <= r_p_valid;
        end
    end

    function automatic logic near(input logic signed [31:0] p, input logic signed [31:0] b,
                                  input logic [15:0] tol);
        logic signed [32:0] d;
        logic [32:0]        m;
        d = {p[31], p} - {b[31], b};
        m = d[32] ? -d : d;
        return m < {17'b0, tol};
    endfunction

    t_face face;
    always_comb begin
        if (near(r_q_pos[0], r_bmin[0], r_face_tol)) begin
            face = FACE_NEG_X;
        end else if (near(r_q_pos[0], r_bmax[0], r_face_tol)) begin
            face = FACE_POS_X;
        end else if (near(r_q_pos[1], r_bmin[1], r_face_tol)) begin
            face = FACE_NEG_Y;
        end else if (near(r_q_pos[1], r_bmax[1], r_face_tol)) begin
            face = FACE_POS_Y;
        end else if (near(r_q_pos[2], r_bmin[2], r_face_tol)) begin
            face = FACE_NEG_Z;
        end else if (near(r_q_pos[2], r_bmax[2], r_face_tol)) begin
            face = FACE_POS_Z;
        end else begin
            face = FACE_NONE;
        end
    end

    logic               r_o_hit, r_o_inside;
    logic [30:0]        r_o_t;
    logic signed [31:0] r_o_pos [0:2];
    logic [2:0]         r_o_face;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_hit <= r_q_res.hit;
            if (r_q_res.hit) begin
                r_o_t      <= r_q_res.t[30:0];
                r_o_inside <= r_q_res.in_box;
                r_o_face   <= face;
                for (int a = 0; a < 3; a++) begin
                    r_o_pos[a] <= r_q_pos[a];
                end
            end else begin
                r_o_t      <= r_q_clo;
                r_o_inside <= 1'b0;
                r_o_face   <= FACE_NONE;
                for (int a = 0; a < 3; a++) begin
                    r_o_pos[a] <= '0;
                end
            end
        end
    end

    assign o_hit.valid       = r_out_valid;
    assign o_hit.hit_found   = r_o_hit;
    assign o_hit.hit_t       = r_o_t;
    assign o_hit.hit_pos_x   = r_o_pos[0];
    assign o_hit.hit_pos_y   = r_o_pos[1];
    assign o_hit.hit_pos_z   = r_o_pos[2];
    assign o_hit.face_code   = r_o_face;
    assign o_hit.from_inside = r_o_inside;

    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_o_hit |-> r_o_face == FACE_NONE && !r_o_inside)
        else $error("miss result carries face or inside flag");

    a_hit_beyond_tol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_o_hit |-> {1'b0, r_o_t} > {16'b0, r_hit_tol})
        else $error("hit distance not above tolerance");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_valid && en |=> r_out_valid)
        else $error("request lost between add stage and output");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_q_valid) && $stable(r_p_valid))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire

// ----- hw/rtl/rbs_div_pipe.sv -----
// pipelined restoring divider, one quotient bit per stage, signed saturated result
// depends on rbs_pkg
`default_nettype none
module rbs_div_pipe (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [rbs_pkg::QW-1:0]       i_num,
    input  wire logic [rbs_pkg::CW-1:0]       i_den,
    input  wire logic                         i_neg,
    output logic signed [rbs_pkg::CW-1:0]     o_quo
);
    import rbs_pkg::*;

    localparam logic [QW-1:0] Q_NEG_LIM = {{(QW-CW){1'b0}}, T_LOW};
    localparam logic [QW-1:0] Q_POS_LIM = {{(QW-CW){1'b0}}, T_HIGH};

    logic [CW-1:0] s_rem [0:QW];
    logic [QW-1:0] s_quo [0:QW];
    logic [QW-1:0] s_num [0:QW];
    logic [CW-1:0] s_den [0:QW];
    logic          s_neg [0:QW];

    assign s_rem[0] = '0;
    assign s_quo[0] = '0;
    assign s_num[0] = i_num;
    assign s_den[0] = i_den;
    assign s_neg[0] = i_neg;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [CW:0]   trial;
        logic          ge;
        logic [CW:0]   diff;
        logic [CW-1:0] r_rem;
        logic [QW-1:0] r_quo;
        logic [QW-1:0] r_num;
        logic [CW-1:0] r_den;
        logic          r_neg;

        assign trial = {s_rem[k], s_num[k][QW-1-k]};
        assign ge    = trial >= {1'b0, s_den[k]};
        assign diff  = trial - {1'b0, s_den[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= ge ? diff[CW-1:0] : trial[CW-1:0];
                r_quo <= {s_quo[k][QW-2:0], ge};
                r_num <= s_num[k];
                r_den <= s_den[k];
                r_neg <= s_neg[k];
            end
        end

        assign s_rem[k+1] = r_rem;
        assign s_quo[k+1] = r_quo;
        assign s_num[k+1] = r_num;
        assign s_den[k+1] = r_den;
        assign s_neg[k+1] = r_neg;
    end

    logic [QW-1:0] q;
    logic [CW-1:0] q_neg;
    assign q     = s_quo[QW];
    assign q_neg = -q[CW-1:0];

    always_comb begin
        if (s_neg[QW]) begin
            o_quo = (q > Q_NEG_LIM) ? T_LOW : q_neg;
        end else begin
            o_quo = (q > Q_POS_LIM) ? T_HIGH : q[CW-1:0];
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/rbs_lane.sv -----
// one axis: two slab divisions, flat-slab handling, sorted entry and exit
// depends on rbs_pkg, rbs_div_pipe
`default_nettype none
module rbs_lane (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [31:0]       i_bmin,
    input  wire logic signed [31:0]       i_bmax,
    input  wire logic signed [31:0]       i_org,
    input  wire logic signed [31:0]       i_dir,
    output rbs_pkg::t_lane_res            o_res
);
    import rbs_pkg::*;

    logic signed [CW:0] d_min, d_max;
    logic [CW:0]        m_min, m_max;
    logic [CW-1:0]      den;
    logic signed [CW-1:0] lo_b, hi_b, q_a, q_b;
    logic               zero, outside;
    logic               r_zd [0:QW-1];
    logic               r_od [0:QW-1];
    t_lane_res          r_res;

    assign d_min = {i_bmin[31], i_bmin} - {i_org[31], i_org};
    assign d_max = {i_bmax[31], i_bmax} - {i_org[31], i_org};
    assign m_min = d_min[CW] ? -d_min : d_min;
    assign m_max = d_max[CW] ? -d_max : d_max;
    assign den   = i_dir[31] ? -i_dir : i_dir;
    assign zero  = (i_dir == '0);
    assign lo_b  = (i_bmin < i_bmax) ? i_bmin : i_bmax;
    assign hi_b  = (i_bmin < i_bmax) ? i_bmax : i_bmin;
    assign outside = (i_org < lo_b) || (i_org > hi_b);

    rbs_div_pipe u_div_min (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ({m_min, {FRAC_BITS{1'b0}}}),
        .i_den (den),
        .i_neg (d_min[CW] ^ i_dir[31]),
        .o_quo (q_a)
    );

    rbs_div_pipe u_div_max (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num ({m_max, {FRAC_BITS{1'b0}}}),
        .i_den (den),
        .i_neg (d_max[CW] ^ i_dir[31]),
        .o_quo (q_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zd[0] <= zero;
            r_od[0] <= outside;
            for (int k = 1; k < QW; k++) begin
                r_zd[k] <= r_zd[k-1];
                r_od[k] <= r_od[k-1];
            end
            if (r_zd[QW-1]) begin
                r_res.lo   <= T_LOW;
                r_res.hi   <= T_HIGH;
                r_res.miss <= r_od[QW-1];
            end else begin
                r_res.lo   <= (q_a < q_b) ? q_a : q_b;
                r_res.hi   <= (q_a < q_b) ? q_b : q_a;
                r_res.miss <= 1'b0;
            end
        end
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

// ----- hw/rtl/rbs_merge.sv -----
// merges the three lanes: entry, exit, inside test and acceptance
// depends on rbs_pkg
`default_nettype none
module rbs_merge (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  rbs_pkg::t_lane_res        i_lx,
    input  rbs_pkg::t_lane_res        i_ly,
    input  rbs_pkg::t_lane_res        i_lz,
    input  wire logic [15:0]          i_hit_tol,
    input  wire logic [30:0]          i_closest,
    output rbs_pkg::t_merge_res       o_res
);
    import rbs_pkg::*;

    logic signed [CW-1:0] ent_xy, ent, ext_xy, ext, tol, tf, clo;
    logic                 miss, in_box;
    t_merge_res           r_res;

    assign tol    = {16'b0, i_hit_tol};
    assign clo    = {1'b0, i_closest};
    assign ent_xy = (i_lx.lo > i_ly.lo) ? i_lx.lo : i_ly.lo;
    assign ent    = (i_lz.lo > ent_xy) ? i_lz.lo : ent_xy;
    assign ext_xy = (i_lx.hi < i_ly.hi) ? i_lx.hi : i_ly.hi;
    assign ext    = (i_lz.hi < ext_xy) ? i_lz.hi : ext_xy;
    assign miss   = i_lx.miss || i_ly.miss || i_lz.miss || (ent > ext) || (ext < tol);
    assign in_box = ent < tol;
    assign tf     = in_box ? ext : ent;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.hit    <= !miss && (tf < clo) && (tf > tol);
            r_res.t      <= tf;
            r_res.in_box <= in_box;
        end
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// testbench for ray_box_slab_intersect: random and directed rays against a configured box
// depends on rbs_pkg, rbs_in_if, rbs_out_if and the block itself; predicts each hit result
`timescale 1ns / 1ps
module tb;
    import rbs_pkg::*;

    typedef struct {
        logic        hit;
        logic [30:0] t;
        logic signed [31:0] px, py, pz;
        logic [2:0]  face;
        logic        from_in;
    } t_hit_rec;

    class hit_scoreboard;
        t_hit_rec pending[$];
        int errors;
        longint bmin[3], bmax[3], hit_tol, face_tol;

        function void set_reg(t_reg_idx idx, logic [31:0] v);
            case (idx) inside
                REG_MIN_X, REG_MIN_Y, REG_MIN_Z: bmin[int'(idx)] = longint'(signed'(v));
                REG_MAX_X, REG_MAX_Y, REG_MAX_Z: bmax[int'(idx) - 3] = longint'(signed'(v));
                REG_HIT_TOL: hit_tol = longint'(v[15:0]);
                default: face_tol = longint'(v[15:0]);
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v < -64'sd2147483648) return -64'sd2147483648;
            if (v > 64'sd2147483647) return 64'sd2147483647;
            return v;
        endfunction

        function void note_ray(logic signed [31:0] o[3], logic signed [31:0] d[3],
                               logic [30:0] closest);
            t_hit_rec r;
            longint a, b, lo, hi, t_in, t_out, t_use, prod, stp, p[3], gap;
            bit miss, from_in;
            t_face f;
            t_in = -64'sd2147483648;
            t_out = 64'sd2147483647;
            miss = 0;
            from_in = 0;
            for (int i = 0; i < 3; i++) begin
                if (d[i] == 0) begin
                    lo = bmin[i] < bmax[i] ? bmin[i] : bmax[i];
                    hi = bmin[i] < bmax[i] ? bmax[i] : bmin[i];
                    if (o[i] < lo || o[i] > hi) miss = 1;
                end else begin
                    a = clamp32(((bmin[i] - o[i]) * 65536) / longint'(d[i]));
                    b = clamp32(((bmax[i] - o[i]) * 65536) / longint'(d[i]));
                    lo = a < b ? a : b;
                    hi = a < b ? b : a;
                    if (lo > t_in) t_in = lo;
                    if (hi < t_out) t_out = hi;
                end
            end
            if (t_in > t_out || t_out < hit_tol) miss = 1;
            t_use = t_in;
            if (t_in < hit_tol) begin
                t_use = t_out;
                from_in = 1;
            end
            r = '{0, closest, 0, 0, 0, FACE_NONE, 0};
            if (!miss && t_use < longint'(closest) && t_use > hit_tol) begin
                for (int i = 0; i < 3; i++) begin
                    prod = t_use * longint'(d[i]);
                    stp = prod >>> FRAC_BITS;
                    p[i] = clamp32(longint'(o[i]) + stp);
                end
                f = FACE_NONE;
                for (int i = 0; i < 3 && f == FACE_NONE; i++) begin
                    gap = p[i] - bmin[i];
                    if (gap < 0) gap = -gap;
                    if (gap < face_tol) f = t_face'(2 * i + 1);
                    else begin
                        gap = p[i] - bmax[i];
                        if (gap < 0) gap = -gap;
                        if (gap < face_tol) f = t_face'(2 * i + 2);
                    end
                end
                r = '{1, t_use[30:0], p[0][31:0], p[1][31:0], p[2][31:0], f, from_in};
            end
            pending.push_back(r);
        endfunction

        function void check_hit(t_hit_rec got);
            t_hit_rec e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result hit=%0d t=%0d", $time, got.hit, got.t);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.hit !== e.hit) begin
                $display("%0t: hit_found exp %0d got %0d", $time, e.hit, got.hit);
                errors++;
            end
            if (got.t !== e.t) begin
                $display("%0t: hit_t exp %0d got %0d", $time, e.t, got.t);
                errors++;
            end
            if (got.px !== e.px) begin
                $display("%0t: hit_pos_x exp %0d got %0d", $time, e.px, got.px);
                errors++;
            end
            if (got.py !== e.py) begin
                $display("%0t: hit_pos_y exp %0d got %0d", $time, e.py, got.py);
                errors++;
            end
            if (got.pz !== e.pz) begin
                $display("%0t: hit_pos_z exp %0d got %0d", $time, e.pz, got.pz);
                errors++;
            end
            if (got.face !== e.face) begin
                $display("%0t: face_code exp %0d got %0d", $time, e.face, got.face);
                errors++;
            end
            if (got.from_in !== e.from_in) begin
                $display("%0t: from_inside exp %0d got %0d", $time, e.from_in, got.from_in);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;
    rbs_in_if  ray_ch();
    rbs_out_if hit_ch();

    ray_box_slab_intersect u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_ray     (ray_ch.sink),
        .o_hit     (hit_ch.source)
    );

    hit_scoreboard sb;
    bit no_idle;
    int quiet_cycles;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN = 80;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // result side: random stall bursts, check on every accepted result
    initial begin
        int burst;
        t_hit_rec got;
        hit_ch.ready = 1'b0;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (hit_ch.valid && hit_ch.ready && i_rst_n) begin
                got = '{hit_ch.hit_found, hit_ch.hit_t, hit_ch.hit_pos_x, hit_ch.hit_pos_y,
                        hit_ch.hit_pos_z, hit_ch.face_code, hit_ch.from_inside};
                sb.check_hit(got);
            end
            @(negedge i_clk);
            if (burst > 0) begin
                burst--;
                hit_ch.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 8) - 1;
                hit_ch.ready <= 1'b0;
            end else begin
                hit_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= v;
        sb.set_reg(idx, v);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic send_ray(logic signed [31:0] o[3], logic signed [31:0] d[3],
                            logic [30:0] closest);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            ray_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        ray_ch.valid <= 1'b1;
        ray_ch.origin_x <= o[0];
        ray_ch.origin_y <= o[1];
        ray_ch.origin_z <= o[2];
        ray_ch.dir_x <= d[0];
        ray_ch.dir_y <= d[1];
        ray_ch.dir_z <= d[2];
        ray_ch.closest_t <= closest;
        do @(posedge i_clk); while (!ray_ch.ready);
        sb.note_ray(o, d, closest);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(longint lo, longint hi);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            2: return 32'd0;
            default: return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
        endcase
    endfunction

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(0, 11))
            0: return 32'd0;
            1: return $urandom;
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            3: return $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
            default: return 32'($signed($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    task automatic random_rays(int count);
        logic signed [31:0] o[3], d[3];
        logic [30:0] closest;
        longint lo, hi, span;
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 3; i++) begin
                lo = sb.bmin[i] < sb.bmax[i] ? sb.bmin[i] : sb.bmax[i];
                hi = sb.bmin[i] < sb.bmax[i] ? sb.bmax[i] : sb.bmin[i];
                span = hi - lo + 1;
                if (span > 64'sd1000000) span = 1000000;
                o[i] = rand_coord(lo - 2 * span < -64'sd2147483648 ? -64'sd2147483648
                                  : lo - 2 * span,
                                  lo + 3 * span > 64'sd2147483647 ? 64'sd2147483647
                                  : lo + 3 * span);
                d[i] = rand_dir();
                // aim most rays toward the box center
                if ($urandom_range(0, 2) != 0) begin
                    d[i] = 32'(((lo + hi) / 2 - longint'(o[i])) / 16
                               + longint'($signed($urandom_range(0, 64))) - 32);
                end
            end
            case ($urandom_range(0, 3))
                0: closest = 31'($urandom);
                1: closest = 31'h7fff_ffff;
                default: closest = 31'($urandom_range(0, 1 << 22));
            endcase
            send_ray(o, d, closest);
        end
        ray_ch.valid <= 1'b0;
    endtask

    initial begin
        logic signed [31:0] o[3], d[3];
        sb = new();
        sb.errors = 0;
        no_idle = 0;
        quiet_cycles = 0;
        for (int i = 0; i < 3; i++) begin
            sb.bmin[i] = 0;
            sb.bmax[i] = 65536;
        end
        sb.hit_tol = 1;
        sb.face_tol = 7;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_MIN_X;
        cfg_data = '0;
        ray_ch.valid = 1'b0;
        ray_ch.origin_x = '0;
        ray_ch.origin_y = '0;
        ray_ch.origin_z = '0;
        ray_ch.dir_x = '0;
        ray_ch.dir_y = '0;
        ray_ch.dir_z = '0;
        ray_ch.closest_t = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rays against the reset box
        o = '{-32'sd65536, 32'sd32768, 32'sd32768};
        d = '{32'sd65536, 32'sd0, 32'sd0};
        send_ray(o, d, 31'h7fff_ffff);
        o = '{32'sd32768, 32'sd32768, 32'sd32768};
        send_ray(o, d, 31'h7fff_ffff);
        d = '{-32'sd65536, 32'sd65536, 32'sd65536};
        send_ray(o, d, 31'h7fff_ffff);
        o = '{32'sd32768, 32'sd200000, 32'sd32768};
        d = '{32'sd65536, 32'sd0, 32'sd0};
        send_ray(o, d, 31'h7fff_ffff);
        o = '{-32'sd65536, 32'sd32768, 32'sd32768};
        send_ray(o, d, 31'd1000);
        send_ray(o, d, 31'd0);
        d = '{32'sd1, 32'sd1, 32'sd1};
        send_ray(o, d, 31'h7fff_ffff);
        o = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        d = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        send_ray(o, d, 31'h7fff_ffff);
        o = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        d = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_ray(o, d, 31'h7fff_ffff);
        o = '{32'sd0, 32'sd0, 32'sd0};
        d = '{32'sd0, 32'sd0, 32'sd0};
        send_ray(o, d, 31'h7fff_ffff);
        o = '{32'sd65536, 32'sd65536, 32'sd65536};
        d = '{-32'sd100, -32'sd70000, 32'sd3};
        send_ray(o, d, 31'h7fff_ffff);
        random_rays(150);
        wait_idle();

        // bounds swapped on x and z, wide tolerances
        write_reg(REG_MIN_X, 32'sd200000);
        write_reg(REG_MAX_X, -32'sd100000);
        write_reg(REG_MIN_Y, -32'sd300000);
        write_reg(REG_MAX_Y, 32'sd50000);
        write_reg(REG_MIN_Z, 32'sd70000);
        write_reg(REG_MAX_Z, 32'sd10000);
        write_reg(REG_HIT_TOL, 32'hffff);
        write_reg(REG_FACE_TOL, 32'hffff);
        random_rays(300);
        wait_idle();

        // extreme box, zero tolerances
        write_reg(REG_MIN_X, 32'h8000_0000);
        write_reg(REG_MIN_Y, 32'h8000_0000);
        write_reg(REG_MIN_Z, 32'h8000_0000);
        write_reg(REG_MAX_X, 32'h7fff_ffff);
        write_reg(REG_MAX_Y, 32'h7fff_ffff);
        write_reg(REG_MAX_Z, 32'h7fff_ffff);
        write_reg(REG_HIT_TOL, 32'h0);
        write_reg(REG_FACE_TOL, 32'h0);
        random_rays(250);
        wait_idle();

        // small random box, random tolerances; final part with no idling
        for (int k = 0; k < 3; k++) begin
            write_reg(REG_MIN_X, 32'($signed($urandom_range(0, 400000)) - 200000));
            write_reg(REG_MIN_Y, 32'($signed($urandom_range(0, 400000)) - 200000));
            write_reg(REG_MIN_Z, 32'($signed($urandom_range(0, 400000)) - 200000));
            write_reg(REG_MAX_X, 32'($signed($urandom_range(0, 400000)) - 200000));
            write_reg(REG_MAX_Y, 32'($signed($urandom_range(0, 400000)) - 200000));
            write_reg(REG_MAX_Z, 32'($signed($urandom_range(0, 400000)) - 200000));
            write_reg(REG_HIT_TOL, $urandom_range(0, 64));
            write_reg(REG_FACE_TOL, $urandom_range(0, 4096));
            if (k == 2) no_idle = 1;
            random_rays(180);
            wait_idle();
        end

        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
